@@ rtl/core/ppg_pkg.sv @@
// ----------------------------------------------------------------------------
// Plasma pixel generator package
// Widths, constants, shared types and the sine and palette tables.
// ----------------------------------------------------------------------------
package ppg_pkg;

  localparam int ANGLE_WIDTH   = 9;
  localparam int PALETTE_WIDTH = 8;
  localparam int DIM_WIDTH     = 12;

  localparam int PHASE_W  = 16;
  localparam int TIME_W   = 32;
  localparam int SINE_W   = 18;
  localparam int ROWSUM_W = SINE_W + 1;
  localparam int TOTAL_W  = SINE_W + 2;
  localparam int MAG_W    = 16;
  localparam int PIXEL_W  = 16;

  localparam int SINE_DEPTH   = 1 << ANGLE_WIDTH;
  localparam int SINE_QUARTER = 1 << (ANGLE_WIDTH - 2);
  localparam int PAL_DEPTH    = 1 << PALETTE_WIDTH;
  localparam int PAL_SEG      = PAL_DEPTH / 4;
  localparam int SINE_ONE     = 65536;
  localparam int CHAN_MAX     = 255;

  localparam int RED_MASK   = 'hf800;
  localparam int GREEN_MASK = 'h07e0;
  localparam int BLUE_MASK  = 'h001f;

  localparam real PI         = 3.14159265358979323846;
  localparam real ANGLE_STEP = PI / real'(1 << (ANGLE_WIDTH - 1));

  localparam logic [PHASE_W-1:0] ROW_STEP_A = PHASE_W'(655);
  localparam logic [PHASE_W-1:0] ROW_STEP_B = PHASE_W'(402);
  localparam logic [PHASE_W-1:0] COL_STEP_A = PHASE_W'(378);
  localparam logic [PHASE_W-1:0] COL_STEP_B = PHASE_W'(270);

  localparam logic [DIM_WIDTH-1:0] FRAME_WIDTH_RST  = DIM_WIDTH'(320);
  localparam logic [DIM_WIDTH-1:0] FRAME_HEIGHT_RST = DIM_WIDTH'(240);

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // time to phase origin: long division of {time, 16'b0} by a constant
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_STEPS      = (TIME_W + PHASE_W) / DIV_RADIX_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);
  localparam int DIV_REM_W      = 12;
  localparam logic [DIV_REM_W-1:0] ROW_TIME_DIV = DIV_REM_W'(1230);
  localparam logic [DIV_REM_W-1:0] COL_TIME_DIV = DIV_REM_W'(3000);

  typedef struct packed {
    logic               busy;
    logic               hit;
    logic [PHASE_W-1:0] row_origin;
    logic [PHASE_W-1:0] col_origin;
  } div_res_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic eol;
    logic eof;
  } pix_ctl_t;

  function automatic logic [SINE_W*(SINE_QUARTER+1)-1:0] build_sine_qtr();
    logic [SINE_W*(SINE_QUARTER+1)-1:0] tbl;
    int v;
    tbl = '0;
    for (int k = 0; k <= SINE_QUARTER; k++) begin
      if (k == SINE_QUARTER) begin
        v = SINE_ONE;
      end else begin
        v = $rtoi($sin(ANGLE_STEP * real'(k)) * real'(SINE_ONE));
      end
      tbl[k*SINE_W +: SINE_W] = SINE_W'(v);
    end
    return tbl;
  endfunction

  localparam logic [SINE_W*(SINE_QUARTER+1)-1:0] SINE_QTR_TBL = build_sine_qtr();

  // full-wave entry from the quarter-wave table
  function automatic logic [SINE_W-1:0] sine_entry(input logic [ANGLE_WIDTH-1:0] idx);
    logic [ANGLE_WIDTH-3:0] pos;
    int k;
    logic [SINE_W-1:0] v;
    pos = idx[ANGLE_WIDTH-3:0];
    if (idx[ANGLE_WIDTH-2]) begin
      k = SINE_QUARTER - int'(pos);
    end else begin
      k = int'(pos);
    end
    v = SINE_QTR_TBL[k*SINE_W +: SINE_W];
    if (idx[ANGLE_WIDTH-1]) begin
      v = '0 - v;
    end
    return v;
  endfunction

  function automatic logic [PIXEL_W-1:0] pack565(input int r, input int g, input int b);
    return PIXEL_W'(((r << 8) & RED_MASK) | ((g << 3) & GREEN_MASK) | ((b >> 3) & BLUE_MASK));
  endfunction

  function automatic logic [PIXEL_W*PAL_DEPTH-1:0] build_palette();
    logic [PIXEL_W*PAL_DEPTH-1:0] tbl;
    int jj;
    tbl = '0;
    for (int k = 0; k < PAL_SEG; k++) begin
      jj = (k * 4 * CHAN_MAX) >> PALETTE_WIDTH;
      tbl[k*PIXEL_W +: PIXEL_W]               = pack565(CHAN_MAX, jj, CHAN_MAX - jj);
      tbl[(PAL_SEG+k)*PIXEL_W +: PIXEL_W]     = pack565(CHAN_MAX - jj, CHAN_MAX, jj);
      tbl[(2*PAL_SEG+k)*PIXEL_W +: PIXEL_W]   = pack565(0, CHAN_MAX - jj, CHAN_MAX);
      tbl[(3*PAL_SEG+k)*PIXEL_W +: PIXEL_W]   = pack565(jj, 0, CHAN_MAX);
    end
    return tbl;
  endfunction

  localparam logic [PIXEL_W*PAL_DEPTH-1:0] PALETTE_TBL = build_palette();

  function automatic logic [PIXEL_W-1:0] palette_color(input logic [PALETTE_WIDTH-1:0] idx);
    return PALETTE_TBL[int'(idx)*PIXEL_W +: PIXEL_W];
  endfunction

endpackage

@@ rtl/core/ppg_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two registered read ports sharing one read enable.
// ----------------------------------------------------------------------------
module ppg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ rtl/core/ppg_phase_div.sv @@
// ----------------------------------------------------------------------------
// Phase origin divider
// floor(t*65536/D) mod 2^16 for both time divisors, four bits per cycle.
// ----------------------------------------------------------------------------
module ppg_phase_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [ppg_pkg::TIME_W-1:0] time_i,
  output ppg_pkg::div_res_t        res_o
);

  import ppg_pkg::*;

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_BUSY = 3'b010,
    DIV_DONE = 3'b100
  } div_state_e;

  div_state_e state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [TIME_W-1:0]    dvd_q;
  logic [TIME_W-1:0]    time_q;
  logic [DIV_REM_W-1:0] rem_row_q, rem_col_q;
  logic [PHASE_W-1:0]   quo_row_q, quo_col_q;
  logic [DIV_REM_W+DIV_RADIX_BITS-1:0] row_step, col_step;
  logic [DIV_RADIX_BITS-1:0] chunk;

  function automatic logic [DIV_REM_W+DIV_RADIX_BITS-1:0] div_chunk(
    input logic [DIV_REM_W-1:0]      rem,
    input logic [DIV_RADIX_BITS-1:0] bits,
    input logic [DIV_REM_W-1:0]      dsor
  );
    logic [DIV_REM_W:0]        r;
    logic [DIV_RADIX_BITS-1:0] q;
    r = {1'b0, rem};
    q = '0;
    for (int i = DIV_RADIX_BITS - 1; i >= 0; i--) begin
      r = {r[DIV_REM_W-1:0], bits[i]};
      if (r >= {1'b0, dsor}) begin
        r    = r - {1'b0, dsor};
        q[i] = 1'b1;
      end
    end
    return {r[DIV_REM_W-1:0], q};
  endfunction

  assign chunk    = dvd_q[TIME_W-1 -: DIV_RADIX_BITS];
  assign row_step = div_chunk(rem_row_q, chunk, ROW_TIME_DIV);
  assign col_step = div_chunk(rem_col_q, chunk, COL_TIME_DIV);

  always_comb begin
    state_d = state_q;
    case (state_q)
      DIV_IDLE: begin
        if (start_i) state_d = DIV_BUSY;
      end
      DIV_BUSY: begin
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = DIV_DONE;
      end
      DIV_DONE: begin
        if (start_i) state_d = DIV_BUSY;
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == DIV_BUSY) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q != DIV_BUSY) begin
      dvd_q     <= time_i;
      time_q    <= time_i;
      rem_row_q <= '0;
      rem_col_q <= '0;
    end else if (state_q == DIV_BUSY) begin
      dvd_q     <= dvd_q << DIV_RADIX_BITS;
      rem_row_q <= row_step[DIV_RADIX_BITS +: DIV_REM_W];
      rem_col_q <= col_step[DIV_RADIX_BITS +: DIV_REM_W];
      quo_row_q <= {quo_row_q[PHASE_W-DIV_RADIX_BITS-1:0], row_step[DIV_RADIX_BITS-1:0]};
      quo_col_q <= {quo_col_q[PHASE_W-DIV_RADIX_BITS-1:0], col_step[DIV_RADIX_BITS-1:0]};
    end
  end

  assign res_o.busy       = (state_q == DIV_BUSY);
  assign res_o.hit        = (state_q == DIV_DONE) && (time_q == time_i);
  assign res_o.row_origin = quo_row_q;
  assign res_o.col_origin = quo_col_q;

endmodule

@@ rtl/core/ppg_raster.sv @@
// ----------------------------------------------------------------------------
// Raster sequencer
// Frame size registers, row/column phases and counters, sine RAM addressing
// and the sine RAM load after reset.
// ----------------------------------------------------------------------------
module ppg_raster (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            frame_start_i,
  input  logic                            take_i,
  input  ppg_pkg::div_res_t               div_res_i,
  output logic                            in_stall_o,
  output logic                            div_start_o,
  input  logic                            cfg_valid_i,
  input  logic [ppg_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ppg_pkg::DIM_WIDTH-1:0]   cfg_data_i,
  output logic                            ram_we_o,
  output logic [ppg_pkg::ANGLE_WIDTH-1:0] ram_waddr_o,
  output logic [ppg_pkg::SINE_W-1:0]      ram_wdata_o,
  output logic [ppg_pkg::ANGLE_WIDTH-1:0] row_raddr_a_o,
  output logic [ppg_pkg::ANGLE_WIDTH-1:0] row_raddr_b_o,
  output logic [ppg_pkg::ANGLE_WIDTH-1:0] col_raddr_a_o,
  output logic [ppg_pkg::ANGLE_WIDTH-1:0] col_raddr_b_o,
  output ppg_pkg::pix_ctl_t               ctl_o
);

  import ppg_pkg::*;

  logic [ANGLE_WIDTH:0]   fill_q;
  logic [DIM_WIDTH-1:0]   frame_width_q, frame_height_q;
  logic [PHASE_W-1:0]     row_org_q, row_org_d, col_org_q, col_org_d;
  logic [PHASE_W-1:0]     row_a_q, row_a_d, row_b_q, row_b_d;
  logic [PHASE_W-1:0]     col_a_q, col_a_d, col_b_q, col_b_d;
  logic [DIM_WIDTH-1:0]   col_cnt_q, col_cnt_d, row_cnt_q, row_cnt_d;
  logic [PHASE_W-1:0]     ra, rb, ca, cb;
  logic [DIM_WIDTH-1:0]   cc, rc, w_last, h_last;
  logic                   filling, ready, fire, first, eol, eof;

  assign filling     = !fill_q[ANGLE_WIDTH];
  assign ready       = !filling && take_i && (!frame_start_i || div_res_i.hit);
  assign fire        = in_valid_i && ready;
  assign in_stall_o  = !ready;
  assign div_start_o = in_valid_i && frame_start_i && !div_res_i.busy && !div_res_i.hit;

  assign ram_we_o    = filling;
  assign ram_waddr_o = fill_q[ANGLE_WIDTH-1:0];
  assign ram_wdata_o = sine_entry(fill_q[ANGLE_WIDTH-1:0]);

  always_comb begin
    row_org_d = row_org_q;
    col_org_d = col_org_q;
    ra        = row_a_q;
    rb        = row_b_q;
    cc        = col_cnt_q;
    rc        = row_cnt_q;
    if (frame_start_i) begin
      row_org_d = div_res_i.row_origin;
      col_org_d = div_res_i.col_origin;
      ra        = div_res_i.row_origin;
      rb        = div_res_i.row_origin;
      cc        = '0;
      rc        = '0;
    end
    first   = (cc == '0);
    ca      = first ? col_org_d : col_a_q;
    cb      = first ? col_org_d : col_b_q;
    row_a_d = first ? ra + ROW_STEP_A : ra;
    row_b_d = first ? rb + ROW_STEP_B : rb;
    col_a_d = ca + COL_STEP_A;
    col_b_d = cb + COL_STEP_B;

    w_last = (frame_width_q == '0) ? '0 : frame_width_q - 1'b1;
    h_last = (frame_height_q == '0) ? '0 : frame_height_q - 1'b1;
    eol    = (cc >= w_last);
    eof    = eol && (rc >= h_last);

    col_cnt_d = cc + 1'b1;
    row_cnt_d = rc;
    if (eol) begin
      col_cnt_d = '0;
      if (eof) begin
        row_cnt_d = '0;
        row_a_d   = row_org_d;
        row_b_d   = row_org_d;
      end else begin
        row_cnt_d = rc + 1'b1;
      end
    end
  end

  assign row_raddr_a_o = ra[PHASE_W-1 -: ANGLE_WIDTH];
  assign row_raddr_b_o = rb[PHASE_W-1 -: ANGLE_WIDTH];
  assign col_raddr_a_o = ca[PHASE_W-1 -: ANGLE_WIDTH];
  assign col_raddr_b_o = cb[PHASE_W-1 -: ANGLE_WIDTH];

  assign ctl_o.valid = fire;
  assign ctl_o.first = first;
  assign ctl_o.eol   = eol;
  assign ctl_o.eof   = eof;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q         <= '0;
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      row_org_q      <= '0;
      col_org_q      <= '0;
      row_a_q        <= '0;
      row_b_q        <= '0;
      col_a_q        <= '0;
      col_b_q        <= '0;
      col_cnt_q      <= '0;
      row_cnt_q      <= '0;
    end else begin
      if (filling) begin
        fill_q <= fill_q + 1'b1;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
          REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (fire) begin
        row_org_q <= row_org_d;
        col_org_q <= col_org_d;
        row_a_q   <= row_a_d;
        row_b_q   <= row_b_d;
        col_a_q   <= col_a_d;
        col_b_q   <= col_b_d;
        col_cnt_q <= col_cnt_d;
        row_cnt_q <= row_cnt_d;
      end
    end
  end

endmodule

@@ rtl/core/ppg_shade.sv @@
// ----------------------------------------------------------------------------
// Shading pipeline
// Sine sum, magnitude and clamp, palette lookup and the output register.
// ----------------------------------------------------------------------------
module ppg_shade (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ppg_pkg::pix_ctl_t             ctl_i,
  output logic                          take_o,
  input  logic [ppg_pkg::SINE_W-1:0]    row_sin_a_i,
  input  logic [ppg_pkg::SINE_W-1:0]    row_sin_b_i,
  input  logic [ppg_pkg::SINE_W-1:0]    col_sin_a_i,
  input  logic [ppg_pkg::SINE_W-1:0]    col_sin_b_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ppg_pkg::PIXEL_W-1:0]   pixel_o,
  output logic                          eol_o,
  output logic                          eof_o
);

  import ppg_pkg::*;

  pix_ctl_t s1_q, s2_q, s3_q;
  logic     out_valid_q, out_eol_q, out_eof_q;
  logic [PIXEL_W-1:0]       pixel_q;
  logic [ROWSUM_W-1:0]      row_sum_q, row_new, row_eff;
  logic [TOTAL_W-1:0]       total_q, total_d;
  logic [SINE_W-1:0]        shifted, mag;
  logic [MAG_W-1:0]         mag_clamp;
  logic [PALETTE_WIDTH-1:0] idx_q, idx_d;
  logic                     rdy2, rdy3, rdy4;

  assign rdy4   = !out_valid_q || !out_stall_i;
  assign rdy3   = !s3_q.valid || rdy4;
  assign rdy2   = !s2_q.valid || rdy3;
  assign take_o = !s1_q.valid || rdy2;

  assign row_new = {row_sin_a_i[SINE_W-1], row_sin_a_i} + {row_sin_b_i[SINE_W-1], row_sin_b_i};
  assign row_eff = s1_q.first ? row_new : row_sum_q;
  assign total_d = {row_eff[ROWSUM_W-1], row_eff}
                 + {{2{col_sin_a_i[SINE_W-1]}}, col_sin_a_i}
                 + {{2{col_sin_b_i[SINE_W-1]}}, col_sin_b_i};

  // floor division by four, then magnitude and clamp
  assign shifted   = total_q[TOTAL_W-1:2];
  assign mag       = shifted[SINE_W-1] ? ('0 - shifted) : shifted;
  assign mag_clamp = (|mag[SINE_W-1:MAG_W]) ? '1 : mag[MAG_W-1:0];
  assign idx_d     = mag_clamp[MAG_W-1 -: PALETTE_WIDTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      s2_q        <= '0;
      s3_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) s1_q <= ctl_i;
      if (rdy2)   s2_q <= s1_q;
      if (rdy3)   s3_q <= s2_q;
      if (rdy4)   out_valid_q <= s3_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      total_q <= total_d;
      if (s1_q.valid && s1_q.first) begin
        row_sum_q <= row_new;
      end
    end
    if (rdy3) begin
      idx_q <= idx_d;
    end
    if (rdy4) begin
      pixel_q   <= palette_color(idx_q);
      out_eol_q <= s3_q.eol;
      out_eof_q <= s3_q.eof;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_o     = pixel_q;
  assign eol_o       = out_eol_q;
  assign eof_o       = out_eof_q;

endmodule

@@ rtl/core/plasma_pixel_generator_core.sv @@
// ----------------------------------------------------------------------------
// Plasma pixel generator core
// Registered RAM read, sum, index, pixel; one pixel per clock if unstalled.
// A frame start with a new time holds the input while the 12-step divider runs.
// Reset clears control, then the sine RAM load stalls the input.
// ----------------------------------------------------------------------------
module plasma_pixel_generator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          frame_start_i,
  input  logic [ppg_pkg::TIME_W-1:0]    time_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ppg_pkg::PIXEL_W-1:0]   pixel_rgb565_o,
  output logic                          end_of_line_o,
  output logic                          end_of_frame_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ppg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ppg_pkg::DIM_WIDTH-1:0] cfg_data_i
);

  import ppg_pkg::*;

  div_res_t div_res;
  pix_ctl_t ctl;
  logic     div_start, take, ram_we;
  logic [ANGLE_WIDTH-1:0] ram_waddr;
  logic [SINE_W-1:0]      ram_wdata;
  logic [ANGLE_WIDTH-1:0] row_raddr_a, row_raddr_b, col_raddr_a, col_raddr_b;
  logic [SINE_W-1:0]      row_sin_a, row_sin_b, col_sin_a, col_sin_b;

  assign cfg_ready_o = 1'b1;

  ppg_phase_div u_phase_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .time_i  (time_ms_i),
    .res_o   (div_res)
  );

  ppg_raster u_raster (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .frame_start_i (frame_start_i),
    .take_i        (take),
    .div_res_i     (div_res),
    .in_stall_o    (in_stall_o),
    .div_start_o   (div_start),
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .row_raddr_a_o (row_raddr_a),
    .row_raddr_b_o (row_raddr_b),
    .col_raddr_a_o (col_raddr_a),
    .col_raddr_b_o (col_raddr_b),
    .ctl_o         (ctl)
  );

  ppg_ram #(
    .Width (SINE_W),
    .Depth (SINE_DEPTH)
  ) u_row_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (take),
    .raddr_a_i (row_raddr_a),
    .raddr_b_i (row_raddr_b),
    .rdata_a_o (row_sin_a),
    .rdata_b_o (row_sin_b)
  );

  ppg_ram #(
    .Width (SINE_W),
    .Depth (SINE_DEPTH)
  ) u_col_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (take),
    .raddr_a_i (col_raddr_a),
    .raddr_b_i (col_raddr_b),
    .rdata_a_o (col_sin_a),
    .rdata_b_o (col_sin_b)
  );

  ppg_shade u_shade (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .take_o      (take),
    .row_sin_a_i (row_sin_a),
    .row_sin_b_i (row_sin_b),
    .col_sin_a_i (col_sin_a),
    .col_sin_b_i (col_sin_b),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pixel_o     (pixel_rgb565_o),
    .eol_o       (end_of_line_o),
    .eof_o       (end_of_frame_o)
  );

  a_fs_needs_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && frame_start_i) |-> div_res.hit)
    else $error("frame start transfer without matching phase origin");

  a_div_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_res.busy && div_res.hit))
    else $error("divider busy and hit together");

  a_eof_is_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_frame_o) |-> end_of_line_o)
    else $error("end of frame without end of line");

endmodule

@@ dv/tb_plasma_pixel_generator_core.sv @@
// ----------------------------------------------------------------------------
// Plasma pixel generator core testbench
// Drives pixel slots and frame starts with random idle gaps on the input side
// and random output stalls. Frame sizes are programmed between phases. An
// in-bench pixel model built from exact sine and palette tables predicts
// every pixel and its row and frame markers. Each output transfer is checked
// in order against the model.
// ----------------------------------------------------------------------------
module tb_plasma_pixel_generator_core;
  import ppg_pkg::TIME_W;
  import ppg_pkg::PIXEL_W;
  import ppg_pkg::DIM_WIDTH;
  import ppg_pkg::CFG_IDX_W;
  import ppg_pkg::ANGLE_WIDTH;
  import ppg_pkg::PALETTE_WIDTH;
  import ppg_pkg::REG_FRAME_WIDTH;
  import ppg_pkg::REG_FRAME_HEIGHT;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 12;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 16;
  localparam int RANDOM_ITEMS = 1000;

  localparam int PHASE_BITS = 16;
  localparam int SINE_ENTRIES = 1 << ANGLE_WIDTH;
  localparam int QUARTER = 1 << (ANGLE_WIDTH - 2);
  localparam int PAL_ENTRIES = 1 << PALETTE_WIDTH;
  localparam int PAL_SEGMENT = PAL_ENTRIES / 4;
  localparam int SINE_PEAK = 65536;
  localparam int MAG_LIMIT = 65535;
  localparam longint unsigned PI_Q60 = 64'h3243F6A8885A308D;
  localparam longint unsigned ROW_TIME_DIVISOR = 64'd1230;
  localparam longint unsigned COL_TIME_DIVISOR = 64'd3000;
  localparam logic [PHASE_BITS-1:0] ROW_ADVANCE_A = 16'd655;
  localparam logic [PHASE_BITS-1:0] ROW_ADVANCE_B = 16'd402;
  localparam logic [PHASE_BITS-1:0] COL_ADVANCE_A = 16'd378;
  localparam logic [PHASE_BITS-1:0] COL_ADVANCE_B = 16'd270;

  typedef struct packed {
    logic [PIXEL_W-1:0] rgb;
    logic               eol;
    logic               eof;
  } pixel_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 frame_start_i = 1'b0;
  logic [TIME_W-1:0]    time_ms_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [PIXEL_W-1:0]   pixel_rgb565_o;
  logic                 end_of_line_o;
  logic                 end_of_frame_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DIM_WIDTH-1:0] cfg_data_i = '0;

  plasma_pixel_generator_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .frame_start_i  (frame_start_i),
    .time_ms_i      (time_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_rgb565_o (pixel_rgb565_o),
    .end_of_line_o  (end_of_line_o),
    .end_of_frame_o (end_of_frame_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // pixel model state
  int                    sine_lut [SINE_ENTRIES];
  logic [PIXEL_W-1:0]    palette_lut [PAL_ENTRIES];
  logic [DIM_WIDTH-1:0]  width_q = 12'd320;
  logic [DIM_WIDTH-1:0]  height_q = 12'd240;
  logic [PHASE_BITS-1:0] row_ang_a = '0;
  logic [PHASE_BITS-1:0] row_ang_b = '0;
  logic [PHASE_BITS-1:0] col_ang_a = '0;
  logic [PHASE_BITS-1:0] col_ang_b = '0;
  logic [PHASE_BITS-1:0] origin_row = '0;
  logic [PHASE_BITS-1:0] origin_col = '0;
  int                    row_sines = 0;
  int                    x_pos = 0;
  int                    y_pos = 0;

  pixel_t expected_pixels [$];
  pixel_t want;
  bit     quiet = 1'b0;
  int     fail_count = 0;
  int     slots_sent = 0;
  int     frame_starts = 0;
  int     reg_writes = 0;
  int     pixels_checked = 0;
  int     frames_done = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // (a*b) >> 60 on Q60 operands
  function automatic longint unsigned fixed_mul60(longint unsigned a, longint unsigned b);
    logic [127:0] prod;
    prod = 128'(a) * 128'(b);
    return prod[123:60];
  endfunction

  // truncated sin(k*pi/2^(ANGLE_WIDTH-1)) * 65536 by Taylor series in Q60
  function automatic int quarter_wave(int k);
    longint unsigned step, frac, kk, x, x2, term, acc;
    int n;
    if (k >= QUARTER) return SINE_PEAK;
    kk = 64'(k);
    step = PI_Q60 >> (ANGLE_WIDTH - 1);
    frac = PI_Q60 & ((64'd1 << (ANGLE_WIDTH - 1)) - 64'd1);
    x = step * kk + ((frac * kk) >> (ANGLE_WIDTH - 1));
    x2 = fixed_mul60(x, x);
    term = x;
    acc = x;
    n = 1;
    while (n < 48 && term != 0) begin
      term = fixed_mul60(term, x2) / (64'(2 * n) * 64'(2 * n + 1));
      if (n % 2 == 1) begin
        acc -= term;
      end else begin
        acc += term;
      end
      n++;
    end
    return int'(acc >> 44);
  endfunction

  function automatic void build_luts();
    int k, seg, v, jj;
    logic [7:0] r, g, b;
    for (k = 0; k <= QUARTER; k++) begin
      v = quarter_wave(k);
      sine_lut[k] = v;
      sine_lut[2 * QUARTER - k] = v;
      sine_lut[2 * QUARTER + k] = -v;
      if (k > 0) begin
        sine_lut[4 * QUARTER - k] = -v;
      end
    end
    for (seg = 0; seg < 4; seg++) begin
      for (k = 0; k < PAL_SEGMENT; k++) begin
        jj = k * 4 * 255 / PAL_ENTRIES;
        case (seg)
          0: begin
            r = 8'd255; g = 8'(jj); b = 8'(255 - jj);
          end
          1: begin
            r = 8'(255 - jj); g = 8'd255; b = 8'(jj);
          end
          2: begin
            r = 8'd0; g = 8'(255 - jj); b = 8'd255;
          end
          default: begin
            r = 8'(jj); g = 8'd0; b = 8'd255;
          end
        endcase
        palette_lut[seg * PAL_SEGMENT + k] = {r[7:3], g[7:2], b[7:3]};
      end
    end
  endfunction

  function automatic int sine_at(logic [PHASE_BITS-1:0] ph);
    return sine_lut[ph >> (PHASE_BITS - ANGLE_WIDTH)];
  endfunction

  function automatic pixel_t render_pixel(logic start, logic [TIME_W-1:0] t);
    pixel_t px;
    longint unsigned scaled;
    int sum4, shifted, mag, w_last, h_last;
    if (start) begin
      scaled = 64'(t) << PHASE_BITS;
      origin_row = PHASE_BITS'(scaled / ROW_TIME_DIVISOR);
      origin_col = PHASE_BITS'(scaled / COL_TIME_DIVISOR);
      row_ang_a = origin_row;
      row_ang_b = origin_row;
      x_pos = 0;
      y_pos = 0;
    end
    if (x_pos == 0) begin
      row_sines = sine_at(row_ang_a) + sine_at(row_ang_b);
      row_ang_a += ROW_ADVANCE_A;
      row_ang_b += ROW_ADVANCE_B;
      col_ang_a = origin_col;
      col_ang_b = origin_col;
    end
    sum4 = row_sines + sine_at(col_ang_a) + sine_at(col_ang_b);
    col_ang_a += COL_ADVANCE_A;
    col_ang_b += COL_ADVANCE_B;
    shifted = sum4 >>> 2;
    mag = (shifted < 0) ? -shifted : shifted;
    if (mag > MAG_LIMIT) mag = MAG_LIMIT;
    w_last = (width_q == 0) ? 0 : int'(width_q) - 1;
    h_last = (height_q == 0) ? 0 : int'(height_q) - 1;
    px.eol = 1'b0;
    px.eof = 1'b0;
    if (x_pos >= w_last) begin
      px.eol = 1'b1;
      x_pos = 0;
      if (y_pos >= h_last) begin
        px.eof = 1'b1;
        y_pos = 0;
        row_ang_a = origin_row;
        row_ang_b = origin_row;
      end else begin
        y_pos++;
      end
    end else begin
      x_pos++;
    end
    px.rgb = palette_lut[mag >> (PHASE_BITS - PALETTE_WIDTH)];
    return px;
  endfunction

  // mostly none or short, a few long
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return {TIME_W{1'b1}};
      2: return TIME_W'($urandom_range(0, 5000));
      default: return TIME_W'($urandom);
    endcase
  endfunction

  initial begin : out_stall_gen
    int span;
    forever begin
      if (quiet) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        span = idle_span();
        if (span > 0) begin
          out_stall_i <= 1'b1;
          repeat (span) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel transfer with nothing expected: rgb %h", pixel_rgb565_o);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (want.eof) frames_done++;
        if (pixel_rgb565_o !== want.rgb) begin
          $error("pixel_rgb565 expected %h actual %h", want.rgb, pixel_rgb565_o);
          fail_count++;
        end
        if (end_of_line_o !== want.eol) begin
          $error("end_of_line expected %b actual %b", want.eol, end_of_line_o);
          fail_count++;
        end
        if (end_of_frame_o !== want.eof) begin
          $error("end_of_frame expected %b actual %b", want.eof, end_of_frame_o);
          fail_count++;
        end
      end
    end
  end

  task automatic send_slot(logic start, logic [TIME_W-1:0] t);
    int gap;
    gap = quiet ? 0 : idle_span();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (!in_valid_i) in_valid_i <= 1'b1;
    frame_start_i <= start;
    time_ms_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    expected_pixels.push_back(render_pixel(start, t));
    slots_sent++;
    if (start) frame_starts++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_WIDTH-1:0] value);
    if (!cfg_valid_i) cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_FRAME_WIDTH) begin
      width_q = value;
    end else if (idx == REG_FRAME_HEIGHT) begin
      height_q = value;
    end
    reg_writes++;
  endtask

  // waits for the pipeline to empty, then writes the size registers
  task automatic program_size(int w, int h, bit stray);
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_FRAME_WIDTH, DIM_WIDTH'(w));
    write_reg(REG_FRAME_HEIGHT, DIM_WIDTH'(h));
    if (stray) begin
      write_reg(CFG_IDX_W'($urandom_range(int'(REG_FRAME_HEIGHT) + 1, (1 << CFG_IDX_W) - 1)),
                DIM_WIDTH'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  // no frame start yet: default size, time taken as zero
  task automatic test_power_on_frame();
    quiet = 1'b1;
    repeat (4) send_slot(1'b0, pick_time());
  endtask

  // widest row and tallest frame, each cut short by shrinking the size
  task automatic test_size_extremes();
    quiet = 1'b0;
    program_size(4095, 4095, 1'b0);
    send_slot(1'b1, 32'd1000);
    repeat (6) send_slot(1'b0, pick_time());
    program_size(3, 4095, 1'b0);
    repeat (2) send_slot(1'b0, pick_time());
    program_size(1, 4095, 1'b1);
    repeat (4) send_slot(1'b0, pick_time());
    program_size(1, 2, 1'b0);
    repeat (2) send_slot(1'b0, pick_time());
  endtask

  // zero registers act as one: every pixel ends a line and a frame
  task automatic test_zero_size();
    program_size(0, 0, 1'b1);
    send_slot(1'b1, pick_time());
    repeat (2) send_slot(1'b0, pick_time());
  endtask

  // restart mid-frame, time extremes, wrap into the next frame
  task automatic test_frame_restarts();
    program_size(2, 2, 1'b0);
    send_slot(1'b1, {TIME_W{1'b1}});
    send_slot(1'b0, pick_time());
    send_slot(1'b1, '0);
    repeat (4) send_slot(1'b0, pick_time());
  endtask

  task automatic test_random_frames();
    int first_slot, w, h, n_pix, cut_at, r, i;
    bit fresh;
    first_slot = slots_sent;
    while (slots_sent - first_slot < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 19);
      if (r == 0) begin
        w = 0;
        h = $urandom_range(0, 3);
      end else if (r < 3) begin
        w = $urandom_range(16, 64);
        h = $urandom_range(1, 2);
      end else begin
        w = $urandom_range(1, 10);
        h = $urandom_range(1, 6);
      end
      program_size(w, h, $urandom_range(0, 3) == 0);
      fresh = ($urandom_range(0, 5) != 0);
      n_pix = $urandom_range(1, 3) * ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
      cut_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, n_pix) : n_pix;
      for (i = 0; i < cut_at; i++) begin
        send_slot((i == 0 && fresh) || $urandom_range(0, 99) < 2, pick_time());
      end
    end
  endtask

  initial begin
    build_luts();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_power_on_frame();
    test_size_extremes();
    test_zero_size();
    test_frame_restarts();
    test_random_frames();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Checked %0d pixels over %0d completed frames", pixels_checked, frames_done);
    $display("Sent %0d slots with %0d frame starts, %0d register writes",
             slots_sent, frame_starts, reg_writes);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
